/* rtl/ffsa_pkg.sv */
// Shared types and constants for the first-fit segment allocator.
// Used by ffsa_seg_ram and first_fit_segment_allocator_top; no dependencies.
`default_nettype none
package ffsa_pkg;

  localparam int MaxSegments = 64;
  localparam int PoolUnits   = 4096;
  localparam int OffW        = 12;
  localparam int LenW        = 13;

  // One table entry: free flag, length, start offset
  typedef struct packed {
    logic            fr;
    logic [LenW-1:0] len;
    logic [OffW-1:0] st;
  } seg_t;

  typedef enum logic [2:0] {
    StOk       = 3'd0,
    StZero     = 3'd1,
    StNoFit    = 3'd2,
    StFull     = 3'd3,
    StNotAlloc = 3'd4
  } status_e;

  typedef enum logic {
    OpAlloc = 1'b0,
    OpFree  = 1'b1
  } opcode_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_NEXT,
    S_UPSH,
    S_WSPLIT,
    S_WBUSY,
    S_MERGE,
    S_DNSH,
    S_RESP
  } state_e;

endpackage
`default_nettype wire

/* rtl/ffsa_seg_ram.sv */
// Segment table storage: one write port, one read port, registered read data.
// Depends on ffsa_pkg for the entry type.
`default_nettype none
module ffsa_seg_ram #(
  parameter int MAX_SEGMENTS = ffsa_pkg::MaxSegments,
  localparam int IW = $clog2(MAX_SEGMENTS)
) (
  input  wire              clk_i,
  input  wire              we_i,
  input  wire [IW-1:0]     waddr_i,
  input  ffsa_pkg::seg_t   wdata_i,
  input  wire [IW-1:0]     raddr_i,
  output ffsa_pkg::seg_t   rdata_o
);

  ffsa_pkg::seg_t mem [MAX_SEGMENTS];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // read port, registered read data
  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule
`default_nettype wire

/* rtl/first_fit_segment_allocator_top.sv */
// First-fit segment allocator, top level: sequencer, output register.
// Depends on ffsa_pkg and ffsa_seg_ram.
`default_nettype none
// The pool is kept as an address-ordered segment table in one synchronous
// RAM. An item (tuser = opcode) is taken only while the sequencer is idle,
// and one result item follows for each. Allocate scans the table one entry
// a cycle until the first fitting free segment, then on a split moves the
// tail up one entry a cycle; free scans for the busy segment, reads its
// successor, writes the merged entry and moves the tail down one entry a
// cycle. After reset and after each pool_size write the block loads entry
// zero before it accepts.
module first_fit_segment_allocator_top #(
  parameter int MAX_SEGMENTS = ffsa_pkg::MaxSegments
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         cfg_we_i,
  input  wire  [12:0] cfg_wdata_i,       // pool_size
  input  wire         s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  wire  [31:0] s_axis_tdata_i,    // [12:0] request_size, [24:13] free_offset
  input  wire         s_axis_tuser_i,    // opcode
  output logic        m_axis_tvalid_o,
  input  wire         m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o     // [2:0] status, [14:3] block_offset
);

  localparam int POOL_UNITS = ffsa_pkg::PoolUnits;
  localparam int IW   = $clog2(MAX_SEGMENTS);
  localparam int CW   = $clog2(MAX_SEGMENTS + 1);
  localparam int OffW = ffsa_pkg::OffW;
  localparam int LenW = ffsa_pkg::LenW;

  ffsa_pkg::state_e state_q, state_d;
  logic [LenW-1:0] pool_q;
  logic            init_q, init_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic            op_q, op_d;
  logic [LenW-1:0] size_q, size_d;
  logic [OffW-1:0] off_q, off_d;
  logic [IW-1:0]   di_q, di_d;
  logic [IW-1:0]   hit_q, hit_d;
  ffsa_pkg::seg_t  ent_q, ent_d, prev_q, wd_q, wd_d;
  logic [IW-1:0]   wa_q, wa_d;
  logic [1:0]      dd_q, dd_d;
  logic [CW-1:0]   kq_q, kq_d;
  logic [IW-1:0]   wk_q, wk_d;
  logic            wv_q, wv_d;
  logic [2:0]      st_q, st_d;
  logic [OffW-1:0] boff_q, boff_d;
  logic            ov_q;
  logic [15:0]     od_q;

  logic            we;
  logic [IW-1:0]   waddr, raddr;
  ffsa_pkg::seg_t  wdata, rd;
  logic [LenW-1:0] units;
  logic [CW-1:0]   di_c, hit_c;
  logic            in_acc, resp_go;

  ffsa_seg_ram #(.MAX_SEGMENTS(MAX_SEGMENTS)) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rd)
  );

  // clamp the configured pool size into range
  always_comb begin
    if (pool_q == '0) begin
      units = LenW'(1);
    end else if (int'(pool_q) > POOL_UNITS) begin
      units = LenW'(POOL_UNITS);
    end else begin
      units = pool_q;
    end
  end

  assign di_c            = CW'(di_q);
  assign hit_c           = CW'(hit_q);
  assign s_axis_tready_o = (state_q == ffsa_pkg::S_IDLE) && !init_q;
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign resp_go         = (state_q == ffsa_pkg::S_RESP) && (!ov_q || m_axis_tready_i);

  // sequencer
  always_comb begin
    state_d = state_q;
    init_d  = init_q;
    cnt_d   = cnt_q;
    op_d    = op_q;
    size_d  = size_q;
    off_d   = off_q;
    di_d    = di_q;
    hit_d   = hit_q;
    ent_d   = ent_q;
    wd_d    = wd_q;
    wa_d    = wa_q;
    dd_d    = dd_q;
    kq_d    = kq_q;
    wk_d    = wk_q;
    wv_d    = 1'b0;
    st_d    = st_q;
    boff_d  = boff_q;
    we      = 1'b0;
    waddr   = '0;
    wdata   = '0;
    raddr   = '0;
    case (state_q)
      ffsa_pkg::S_IDLE: begin
        if (init_q) begin
          // load entry zero with the whole pool
          we     = 1'b1;
          wdata  = '{fr: 1'b1, len: units, st: '0};
          init_d = 1'b0;
          cnt_d  = CW'(1);
        end else if (in_acc) begin
          op_d   = s_axis_tuser_i;
          size_d = s_axis_tdata_i[12:0];
          off_d  = s_axis_tdata_i[24:13];
          st_d   = ffsa_pkg::StOk;
          boff_d = '0;
          di_d   = '0;
          raddr  = '0;
          if (s_axis_tuser_i == ffsa_pkg::OpAlloc && s_axis_tdata_i[12:0] == '0) begin
            st_d    = ffsa_pkg::StZero;
            state_d = ffsa_pkg::S_RESP;
          end else begin
            state_d = ffsa_pkg::S_SCAN;
          end
        end
      end
      ffsa_pkg::S_SCAN: begin
        // rd holds entry di_q; fetch the following one
        raddr = di_q + IW'(1);
        di_d  = di_q + IW'(1);
        hit_d = di_q;
        ent_d = rd;
        if (op_q == ffsa_pkg::OpAlloc) begin
          if (rd.fr && rd.len >= size_q) begin
            if (rd.len == size_q) begin
              state_d = ffsa_pkg::S_WBUSY;
            end else if (cnt_q == CW'(MAX_SEGMENTS)) begin
              st_d    = ffsa_pkg::StFull;
              state_d = ffsa_pkg::S_RESP;
            end else begin
              kq_d    = cnt_q;
              state_d = ffsa_pkg::S_UPSH;
            end
          end else if (di_c == cnt_q - CW'(1)) begin
            st_d    = ffsa_pkg::StNoFit;
            state_d = ffsa_pkg::S_RESP;
          end
        end else begin
          if (!rd.fr && rd.st == off_q) begin
            state_d = ffsa_pkg::S_NEXT;
          end else if (di_c == cnt_q - CW'(1)) begin
            st_d    = ffsa_pkg::StNotAlloc;
            state_d = ffsa_pkg::S_RESP;
          end
        end
      end
      ffsa_pkg::S_NEXT: begin
        // rd holds the successor; pick the merge case
        if ((hit_q != '0) && prev_q.fr) begin
          wa_d = hit_q - IW'(1);
          wd_d = '{fr: 1'b1, len: prev_q.len + ent_q.len, st: prev_q.st};
          kq_d = hit_c;
          dd_d = 2'd1;
          if ((hit_c + CW'(1) < cnt_q) && rd.fr) begin
            wd_d.len = prev_q.len + ent_q.len + rd.len;
            dd_d     = 2'd2;
          end
        end else begin
          wa_d = hit_q;
          wd_d = '{fr: 1'b1, len: ent_q.len, st: ent_q.st};
          kq_d = hit_c + CW'(1);
          dd_d = 2'd0;
          if ((hit_c + CW'(1) < cnt_q) && rd.fr) begin
            wd_d.len = ent_q.len + rd.len;
            dd_d     = 2'd1;
          end
        end
        state_d = ffsa_pkg::S_MERGE;
      end
      ffsa_pkg::S_MERGE: begin
        we    = 1'b1;
        waddr = wa_q;
        wdata = wd_q;
        // kq becomes the source pointer, wk the destination
        wk_d  = kq_q[IW-1:0];
        kq_d  = kq_q + CW'(dd_q);
        state_d = (dd_q == 2'd0) ? ffsa_pkg::S_RESP : ffsa_pkg::S_DNSH;
      end
      ffsa_pkg::S_DNSH: begin
        // move the tail down by dd_q entries
        if (wv_q) begin
          we    = 1'b1;
          waddr = wk_q;
          wdata = rd;
          wk_d  = wk_q + IW'(1);
        end
        if (kq_q < cnt_q) begin
          raddr = kq_q[IW-1:0];
          kq_d  = kq_q + CW'(1);
          wv_d  = 1'b1;
        end else begin
          cnt_d   = cnt_q - CW'(dd_q);
          state_d = ffsa_pkg::S_RESP;
        end
      end
      ffsa_pkg::S_UPSH: begin
        // move the tail up by one entry, top first
        if (wv_q) begin
          we    = 1'b1;
          waddr = wk_q;
          wdata = rd;
        end
        if (kq_q > hit_c + CW'(1)) begin
          raddr = IW'(kq_q - CW'(1));
          wk_d  = kq_q[IW-1:0];
          kq_d  = kq_q - CW'(1);
          wv_d  = 1'b1;
        end else begin
          state_d = ffsa_pkg::S_WSPLIT;
        end
      end
      ffsa_pkg::S_WSPLIT: begin
        we    = 1'b1;
        waddr = hit_q + IW'(1);
        wdata = '{fr: 1'b1, len: ent_q.len - size_q, st: ent_q.st + size_q[OffW-1:0]};
        cnt_d = cnt_q + CW'(1);
        state_d = ffsa_pkg::S_WBUSY;
      end
      ffsa_pkg::S_WBUSY: begin
        we     = 1'b1;
        waddr  = hit_q;
        wdata  = '{fr: 1'b0, len: size_q, st: ent_q.st};
        boff_d = ent_q.st;
        state_d = ffsa_pkg::S_RESP;
      end
      ffsa_pkg::S_RESP: begin
        if (resp_go) begin
          state_d = ffsa_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = ffsa_pkg::S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ffsa_pkg::S_IDLE;
      init_q  <= 1'b1;
      pool_q  <= LenW'(4096);
      cnt_q   <= CW'(1);
      wv_q    <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      wv_q    <= wv_d;
      if (cfg_we_i) begin
        pool_q <= cfg_wdata_i;
        init_q <= 1'b1;
      end else begin
        init_q <= init_d;
      end
      if (resp_go) begin
        ov_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    op_q   <= op_d;
    size_q <= size_d;
    off_q  <= off_d;
    di_q   <= di_d;
    hit_q  <= hit_d;
    ent_q  <= ent_d;
    // during the scan ent_q holds the entry before the one on rd
    if (state_q == ffsa_pkg::S_SCAN) begin
      prev_q <= ent_q;
    end
    wd_q   <= wd_d;
    wa_q   <= wa_d;
    dd_q   <= dd_d;
    kq_q   <= kq_d;
    wk_q   <= wk_d;
    st_q   <= st_d;
    boff_q <= boff_d;
    // boff_q stays zero unless an allocate succeeds
    if (resp_go) begin
      od_q <= {1'b0, boff_q, st_q};
    end
  end

  assign m_axis_tvalid_o = ov_q;
  assign m_axis_tdata_o  = od_q;

`ifndef NO_ASSERTIONS
  // the table never empties nor overflows
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != '0) && (cnt_q <= CW'(MAX_SEGMENTS)))
    else $error("segment count out of range");

  // an accepted item always starts work
  a_acc_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q != ffsa_pkg::S_IDLE))
    else $error("accepted item left sequencer idle");

  // scanning never modifies the table
  a_scan_ro: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ffsa_pkg::S_SCAN || state_q == ffsa_pkg::S_NEXT) |-> !we)
    else $error("table write during scan");

  // a result is only loaded while the output slot can take it
  a_out_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && !m_axis_tready_i) |-> !resp_go)
    else $error("result overwrote a pending item");
`endif

endmodule
`default_nettype wire
